@@ hw/rtl/nads_pkg.sv @@
package nads_pkg;

  // one input item as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } nads_item_t;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       token_end;
    logic       stream_end;
  } nads_res_t;

  // configuration register indexes
  localparam logic [2:0] CFG_DELIM_BYTES = 3'd0;
  localparam logic [2:0] CFG_DELIM_LEN   = 3'd1;
  localparam logic [2:0] CFG_PAIR_TABLE  = 3'd2;
  localparam logic [2:0] CFG_PAIR_COUNT  = 3'd3;
  localparam logic [2:0] CFG_KEEP_EMPTY  = 3'd4;

  // depth saturation bound
  localparam logic signed [16:0] DEPTH_LIMIT = 17'sd32767;

endpackage

@@ hw/rtl/nads_queue.sv @@
module nads_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  nads_pkg::nads_item_t wr_item_i,
  output logic               rd_valid_o,
  input  logic               rd_pop_i,
  output nads_pkg::nads_item_t rd_item_o
);
  import nads_pkg::*;

  nads_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;

  // two-entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (rd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(rd_pop_i);
    end
  end

endmodule

@@ hw/rtl/nads_engine.sv @@
module nads_engine #(
  parameter int DELIM_MAX  = 4,
  parameter int PAIR_SLOTS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          delim_bytes_i,
  input  logic [2:0]           delim_len_i,
  input  logic [63:0]          pair_table_i,
  input  logic [2:0]           pair_count_i,
  input  logic                 keep_empty_i,
  input  logic                 q_valid_i,
  input  nads_pkg::nads_item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nads_pkg::nads_res_t  out_res_o
);
  import nads_pkg::*;

  localparam int FW = $clog2(DELIM_MAX + 1);

  logic [7:0]        buf_q [DELIM_MAX];
  logic [7:0]        buf_d [DELIM_MAX];
  logic [FW-1:0]     fill_q, fill_d, skip_q, skip_d;
  logic signed [15:0] depth_q, depth_d;
  logic [PAIR_SLOTS-1:0] flags_q, flags_d;
  logic              nonempty_q, nonempty_d;
  logic              active_q, active_d, last_q, last_d;
  logic              ov_q, ov_d;
  nads_res_t         res_q, res_d;

  logic [FW-1:0]     len;
  logic [7:0]        db [DELIM_MAX];
  logic [7:0]        vb [DELIM_MAX];
  logic [FW-1:0]     vfill;
  logic              vlast, vcond, cur_cond, cur_done, free, go, pop, engage;
  logic              match, found, emit;
  logic [7:0]        c, op, cl;
  logic signed [1:0] delta;
  logic signed [16:0] sum;
  logic signed [15:0] nd;
  nads_res_t         e_res;

  // effective delimiter length and delimiter bytes
  always_comb begin
    if (delim_len_i == 3'd0) len = FW'(1);
    else if (int'(delim_len_i) > DELIM_MAX) len = FW'(DELIM_MAX);
    else len = FW'(delim_len_i);
    for (int k = 0; k < DELIM_MAX; k++) begin
      if (k < 4) db[k] = delim_bytes_i[8*(k%4) +: 8];
      else db[k] = 8'd0;
    end
  end

  // control, lookahead view and one processing step
  always_comb begin
    cur_cond = (fill_q != '0) && ((skip_q != '0) || (fill_q >= len) || last_q);
    cur_done = active_q && !cur_cond && !last_q;
    free     = !active_q || cur_done;
    go       = !ov_q || out_ready_i;
    pop      = free && q_valid_i && go;
    engage   = go && (pop || (active_q && !cur_done));

    vb    = buf_q;
    vfill = fill_q;
    vlast = last_q;
    if (pop) begin
      vlast = q_item_i.last;
      if (int'(fill_q) < DELIM_MAX) begin
        for (int k = 0; k < DELIM_MAX; k++) begin
          if (k == int'(fill_q)) vb[k] = q_item_i.data;
        end
        vfill = fill_q + FW'(1);
      end
    end
    vcond = (vfill != '0) && ((skip_q != '0) || (vfill >= len) || vlast);

    buf_d      = buf_q;
    fill_d     = fill_q;
    skip_d     = skip_q;
    depth_d    = depth_q;
    flags_d    = flags_q;
    nonempty_d = nonempty_q;
    active_d   = active_q;
    last_d     = last_q;
    emit       = 1'b0;
    e_res      = '0;
    c          = vb[0];
    found      = 1'b0;
    delta      = 2'sd0;
    op         = 8'd0;
    cl         = 8'd0;

    if (cur_done && !pop) active_d = 1'b0;
    if (pop) begin
      active_d = 1'b1;
      last_d   = q_item_i.last;
    end

    // first pair holding the head byte sets the depth change
    for (int s = 0; s < PAIR_SLOTS; s++) begin
      if (s < 4) begin
        op = pair_table_i[16*(s%4) +: 8];
        cl = pair_table_i[16*(s%4)+8 +: 8];
      end else begin
        op = 8'd0;
        cl = 8'd0;
      end
      if (!found && (s < int'(pair_count_i)) && (c == op || c == cl)) begin
        found = 1'b1;
        if (op == cl) begin
          delta = flags_q[s] ? -2'sd1 : 2'sd1;
        end else if (c == op) begin
          delta = 2'sd1;
        end else begin
          delta = -2'sd1;
        end
      end
    end
    sum = 17'(depth_q) + 17'(delta);
    if (sum > DEPTH_LIMIT) nd = DEPTH_LIMIT[15:0];
    else if (sum < -DEPTH_LIMIT) nd = -DEPTH_LIMIT[15:0];
    else nd = sum[15:0];

    // delimiter at the head of the lookahead
    match = (vfill >= len);
    for (int k = 0; k < DELIM_MAX; k++) begin
      if (k < int'(len) && vb[k] != db[k]) match = 1'b0;
    end

    if (engage) begin
      buf_d  = vb;
      fill_d = vfill;
      if (vcond) begin
        for (int k = 0; k < DELIM_MAX - 1; k++) buf_d[k] = vb[k+1];
        buf_d[DELIM_MAX-1] = 8'd0;
        fill_d = vfill - FW'(1);
        if (skip_q != '0) begin
          skip_d = skip_q - FW'(1);
        end else begin
          depth_d = nd;
          // symmetric pair toggles its own flag
          for (int s = 0; s < PAIR_SLOTS; s++) begin
            if (s < 4 && s < int'(pair_count_i)
                && pair_table_i[16*(s%4) +: 8] == pair_table_i[16*(s%4)+8 +: 8]
                && c == pair_table_i[16*(s%4) +: 8]) begin
              // only the first matching slot counts
              if (found && delta != 2'sd0) begin
                flags_d[s] = ~flags_q[s];
                found = 1'b0;
              end
            end else if (s < 4 && s < int'(pair_count_i)
                         && (c == pair_table_i[16*(s%4) +: 8]
                             || c == pair_table_i[16*(s%4)+8 +: 8])) begin
              found = 1'b0;
            end
          end
          if (nd == 16'sd0 && match) begin
            if (nonempty_q || keep_empty_i) begin
              emit            = 1'b1;
              e_res.token_end = 1'b1;
            end
            nonempty_d = 1'b0;
            skip_d     = len - FW'(1);
          end else begin
            emit           = 1'b1;
            e_res.data     = c;
            e_res.has_byte = 1'b1;
            nonempty_d     = 1'b1;
          end
        end
      end else if (vlast) begin
        emit             = 1'b1;
        e_res.token_end  = nonempty_q || keep_empty_i;
        e_res.stream_end = 1'b1;
        for (int k = 0; k < DELIM_MAX; k++) buf_d[k] = 8'd0;
        fill_d     = '0;
        skip_d     = '0;
        depth_d    = 16'sd0;
        flags_d    = '0;
        nonempty_d = 1'b0;
        active_d   = 1'b0;
      end else begin
        active_d = 1'b0;
      end
    end

    ov_d  = ov_q;
    res_d = res_q;
    if (go) begin
      ov_d  = emit;
      res_d = e_res;
    end
  end

  assign q_pop_o     = pop;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  // result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DELIM_MAX; k++) buf_q[k] <= 8'd0;
      fill_q     <= '0;
      skip_q     <= '0;
      depth_q    <= 16'sd0;
      flags_q    <= '0;
      nonempty_q <= 1'b0;
      active_q   <= 1'b0;
      last_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      buf_q      <= buf_d;
      fill_q     <= fill_d;
      skip_q     <= skip_d;
      depth_q    <= depth_d;
      flags_q    <= flags_d;
      nonempty_q <= nonempty_d;
      active_q   <= active_d;
      last_q     <= last_d;
      ov_q       <= ov_d;
    end
  end

  // lookahead never holds more than its depth
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= DELIM_MAX) else $error("lookahead overfilled");

  // pending skips stay below the delimiter length bound
  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(skip_q) < DELIM_MAX) else $error("skip count out of range");

  // depth stays within saturation bounds
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (17'(depth_q) <= DEPTH_LIMIT) && (17'(depth_q) >= -DEPTH_LIMIT))
    else $error("depth out of range");

  // an end-of-string marker leaves the stream state cleared
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (engage && !vcond && vlast) |=> (fill_q == '0 && depth_q == 16'sd0 && !active_q))
    else $error("stream state not cleared at end of string");

endmodule

@@ hw/rtl/nesting_aware_delimiter_splitter.sv @@
// Splits a byte stream into tokens at a 1 to DELIM_MAX byte delimiter, only where the
// bracket/quote nesting depth is zero. Bytes enter on s_axis (tlast on the final byte of a
// string), and leave on m_axis as results: a token byte, a token-end marker, or the
// end-of-string marker. A two-entry input queue decouples intake from the engine, which
// handles one lookahead step per cycle while the output is not stalled, so ordinary text
// runs at one byte per cycle; each skipped delimiter byte after the first is dropped in a
// step of its own, and at a string end the held bytes are flushed before its marker is
// emitted. Up to DELIM_MAX - 1 bytes are held back for delimiter lookahead. The
// configuration port is always ready; write it only while no string is in flight.
module nesting_aware_delimiter_splitter #(
  parameter int DELIM_MAX  = 4,
  parameter int PAIR_SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [2:0]  m_axis_tuser,   // has_byte, token_end, stream_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i
);
  import nads_pkg::*;

  logic [31:0] delim_bytes_q;
  logic [2:0]  delim_len_q;
  logic [63:0] pair_table_q;
  logic [2:0]  pair_count_q;
  logic        keep_empty_q;

  nads_item_t  in_item, q_item;
  logic        q_valid, q_pop;
  nads_res_t   res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_bytes_q <= 32'd44;
      delim_len_q   <= 3'd1;
      pair_table_q  <= 64'd0;
      pair_count_q  <= 3'd0;
      keep_empty_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_DELIM_BYTES: delim_bytes_q <= cfg_data_i[31:0];
        CFG_DELIM_LEN:   delim_len_q   <= cfg_data_i[2:0];
        CFG_PAIR_TABLE:  pair_table_q  <= cfg_data_i;
        CFG_PAIR_COUNT:  pair_count_q  <= cfg_data_i[2:0];
        CFG_KEEP_EMPTY:  keep_empty_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // intake queue
  nads_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_item_i  (in_item),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_item_o  (q_item)
  );

  // tokenizing engine
  nads_engine #(
    .DELIM_MAX  (DELIM_MAX),
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delim_bytes_i (delim_bytes_q),
    .delim_len_i   (delim_len_q),
    .pair_table_i  (pair_table_q),
    .pair_count_i  (pair_count_q),
    .keep_empty_i  (keep_empty_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {res.stream_end, res.token_end, res.has_byte};

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nads_pkg::*;

  // one stimulus row: input item, plus typed-in results where n_typed >= 0
  typedef struct {
    nads_item_t item;
    int         n_typed;
    nads_res_t  typed0;
    nads_res_t  typed1;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_data = '0;

  nesting_aware_delimiter_splitter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),   // has_byte, token_end, stream_end
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow registers
  logic [31:0] sh_delim  = 32'd44;
  logic [2:0]  sh_len    = 3'd1;
  logic [63:0] sh_pairs  = '0;
  logic [2:0]  sh_npairs = '0;
  logic        sh_keep   = 1'b0;

  // shadow stream state
  logic [7:0] held [4];
  int         held_fill;
  int         skip_left;
  int         depth;
  bit [3:0]   quote_open;
  bit         token_open;

  stim_row_t  byte_queue [$];
  nads_res_t  split_out [$];
  nads_res_t  pending_res [$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         rx_hold = 1'b0;
  int         rx_mode = 0;
  int         rx_cyc = 0;

  function automatic void clear_shadow();
    for (int k = 0; k < 4; k++) held[k] = '0;
    held_fill = 0;
    skip_left = 0;
    depth = 0;
    quote_open = '0;
    token_open = 1'b0;
  endfunction

  function automatic void drop_held();
    for (int k = 1; k < 4; k++) held[k-1] = held[k];
    held[3] = '0;
    if (held_fill > 0) held_fill--;
  endfunction

  // first pair holding the byte moves the depth
  function automatic void nest_step(logic [7:0] c);
    int n;
    logic [7:0] op, cl;
    n = (sh_npairs > 4) ? 4 : sh_npairs;
    for (int s = 0; s < n; s++) begin
      op = sh_pairs[16*s +: 8];
      cl = sh_pairs[16*s+8 +: 8];
      if (c == op || c == cl) begin
        if (op == cl) begin
          depth += quote_open[s] ? -1 : 1;
          quote_open[s] = !quote_open[s];
        end else begin
          depth += (c == op) ? 1 : -1;
        end
        if (depth > 32767) depth = 32767;
        if (depth < -32767) depth = -32767;
        return;
      end
    end
  endfunction

  // results caused by one byte land in split_out
  function automatic void split_predict(logic [7:0] b, logic last);
    int len;
    bit hit;
    logic [7:0] c;
    split_out.delete();
    len = (sh_len < 1) ? 1 : (sh_len > 4) ? 4 : sh_len;
    if (held_fill < 4) begin
      held[held_fill] = b;
      held_fill++;
    end
    while (held_fill > 0 && (skip_left > 0 || held_fill >= len || last)) begin
      if (skip_left > 0) begin
        drop_held();
        skip_left--;
        continue;
      end
      c = held[0];
      nest_step(c);
      hit = (depth == 0) && (held_fill >= len);
      for (int k = 0; k < len; k++)
        if (held[k] != sh_delim[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        if (token_open || sh_keep)
          split_out.insert(split_out.size(), '{8'h00, 1'b0, 1'b1, 1'b0});
        token_open = 1'b0;
        drop_held();
        skip_left = len - 1;
      end else begin
        split_out.insert(split_out.size(), '{c, 1'b1, 1'b0, 1'b0});
        token_open = 1'b1;
        drop_held();
      end
    end
    if (last) begin
      split_out.insert(split_out.size(), '{8'h00, 1'b0, token_open || sh_keep, 1'b1});
      clear_shadow();
    end
  endfunction

  // receiver: stall pattern redrawn at regular intervals, plus a long hold on demand
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_tready <= !rx_hold;
      1:       m_tready <= !rx_hold && ($urandom_range(0, 1) == 1);
      2:       m_tready <= !rx_hold && (rx_cyc % 5 != 0);
      default: m_tready <= !rx_hold && ($urandom_range(0, 7) == 0);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    nads_res_t got, want;
    if (m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser[0], m_tuser[1], m_tuser[2]};
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $realtime, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.data !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $realtime, want.data, got.data);
          errors++;
        end
        if (got.has_byte !== want.has_byte) begin
          $display("%0t: has_byte expected %b actual %b", $realtime, want.has_byte,
                   got.has_byte);
          errors++;
        end
        if (got.token_end !== want.token_end) begin
          $display("%0t: token_end expected %b actual %b", $realtime, want.token_end,
                   got.token_end);
          errors++;
        end
        if (got.stream_end !== want.stream_end) begin
          $display("%0t: stream_end expected %b actual %b", $realtime, want.stream_end,
                   got.stream_end);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("%0t: watchdog expired, %0d results outstanding", $realtime,
               pending_res.size());
      $display("** nesting_aware_delimiter_splitter: FAILED **");
      $finish;
    end
  end

  // sender: bursts of random length with random gaps
  task automatic send_bytes();
    int burst, gap;
    stim_row_t r;
    while (byte_queue.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && byte_queue.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= byte_queue[0].item.data;
        s_tlast  <= byte_queue[0].item.last;
        @(posedge clk_i);
        while (!s_tready) @(posedge clk_i);
        r = byte_queue.pop_front();
        split_predict(r.item.data, r.item.last);
        if (r.n_typed < 0) begin
          foreach (split_out[k]) pending_res.insert(pending_res.size(), split_out[k]);
        end else begin
          if (r.n_typed > 0) pending_res.insert(pending_res.size(), r.typed0);
          if (r.n_typed > 1) pending_res.insert(pending_res.size(), r.typed1);
        end
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 || byte_queue.size() == 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    while (pending_res.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (addr)
      CFG_DELIM_BYTES: sh_delim  = data[31:0];
      CFG_DELIM_LEN:   sh_len    = data[2:0];
      CFG_PAIR_TABLE:  sh_pairs  = data;
      CFG_PAIR_COUNT:  sh_npairs = data[2:0];
      CFG_KEEP_EMPTY:  sh_keep   = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] dl, logic [2:0] ln, logic [63:0] pt,
                            logic [2:0] pc, logic ke);
    cfg_write(CFG_DELIM_BYTES, {32'h0, dl});
    cfg_write(CFG_DELIM_LEN, {61'h0, ln});
    cfg_write(CFG_PAIR_TABLE, pt);
    cfg_write(CFG_PAIR_COUNT, {61'h0, pc});
    cfg_write(CFG_KEEP_EMPTY, {63'h0, ke});
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_byte(logic [7:0] b, logic last);
    byte_queue.insert(byte_queue.size(), '{'{b, last}, -1, '0, '0});
  endfunction

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k], k == s.len() - 1);
  endfunction

  // well-formed-ish strings drawn mostly from delimiter and pair bytes
  function automatic void add_random_strings(int n_bytes);
    logic [7:0] pool [$];
    int len;
    for (int k = 0; k < 4; k++) pool.insert(pool.size(), sh_delim[8*k +: 8]);
    for (int k = 0; k < 8; k++) pool.insert(pool.size(), sh_pairs[8*k +: 8]);
    pool.insert(pool.size(), "a");
    pool.insert(pool.size(), "b");
    while (n_bytes > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 30) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++)
        add_byte(($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, pool.size() - 1)]
                                             : 8'($urandom), k == len - 1);
      n_bytes -= len;
    end
  endfunction

  function automatic logic [7:0] pick_sym();
    logic [7:0] sym [8] = '{"(", ")", "[", "]", 8'h22, "'", ",", ";"};
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : sym[$urandom_range(0, 7)];
  endfunction

  function automatic logic [63:0] random_pairs();
    logic [63:0] pt;
    logic [7:0] op;
    if ($urandom_range(0, 5) == 0) return {$urandom, $urandom};
    for (int s = 0; s < 4; s++) begin
      op = pick_sym();
      pt[16*s +: 16] = ($urandom_range(0, 2) == 0) ? {op, op} : {pick_sym(), op};
    end
    return pt;
  endfunction

  // typed-in rows under the reset configuration: delimiter ',' and no pairs
  stim_row_t reset_rows [5] = '{
    '{'{"x", 1'b0},   1, '{"x", 1'b1, 1'b0, 1'b0}, '0},
    '{'{",", 1'b0},   1, '{8'h00, 1'b0, 1'b1, 1'b0}, '0},
    '{'{",", 1'b0},   0, '0, '0},
    '{'{8'h00, 1'b0}, 1, '{8'h00, 1'b1, 1'b0, 1'b0}, '0},
    '{'{8'hFF, 1'b1}, 2, '{8'hFF, 1'b1, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  initial begin
    clear_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults after reset
    foreach (reset_rows[k]) byte_queue.insert(byte_queue.size(), reset_rows[k]);
    add_text(",");
    send_bytes();
    drain();

    // directed: brackets, quotes, 3-byte delimiter, empty tokens kept
    set_config({8'h00, ";", ":", ":"}, 3'd3,
               {16'h0, 16'h2727, {8'h22, 8'h22}, {")", "("}}, 3'd3, 1'b1);
    add_text("a::;b(::;)::;::;");
    add_text("\"x::;\"'::;'::;");
    add_text(")::;(::");
    add_text("::;");
    add_text(":");
    send_bytes();
    drain();

    // directed: length zero reads as one, count above slots, all-zero symmetric pairs
    set_config(32'h0000_0030, 3'd0, 64'h0, 3'd7, 1'b0);
    add_text("000a0");
    add_byte(8'h00, 1'b0);
    add_byte("b", 1'b0);
    add_byte(8'h00, 1'b1);
    send_bytes();
    drain();

    // directed: length above max reads as four, all-ones registers
    set_config(32'hFFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 3'd5, 1'b1);
    for (int k = 0; k < 10; k++) add_byte(8'hFF, k == 9);
    for (int k = 0; k < 5; k++) add_byte((k % 2) ? 8'hFF : 8'h7E, k == 4);
    send_bytes();
    drain();

    // random phases, each with fresh configuration
    for (int ph = 0; ph < 8; ph++) begin
      set_config($urandom, 3'($urandom_range(0, 7)), random_pairs(),
                 3'($urandom_range(0, 7)), 1'($urandom));
      if (ph == 2) begin
        add_random_strings(50);
        fork
          send_bytes();
          begin
            rx_hold = 1'b1;
            repeat (300) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join
      end else if (ph == 4) begin
        add_random_strings(25);
        send_bytes();
        while (pending_res.size() > 0) @(posedge clk_i);
        add_random_strings(25);
        send_bytes();
      end else begin
        add_random_strings(45);
        send_bytes();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** nesting_aware_delimiter_splitter: PASSED **");
    end else begin
      $display("** nesting_aware_delimiter_splitter: FAILED **");
    end
    $finish;
  end

endmodule
